/* design/salwc_pkg.sv */
package salwc_pkg;

  // Field widths of the request and response beats.
  localparam int ADDRESS_W      = 32;
  localparam int INSTR_W        = 16;
  localparam int ACC_CYC_W      = 17;
  localparam int SUM_W          = 48;
  localparam int CNT_W          = 32;

  // Configuration register file.
  localparam int PENALTY_W      = 10;
  localparam int APB_DATA_W     = 32;
  localparam int PADDR_W        = 3;
  localparam int REG_IDX_W      = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_PENALTY   = REG_IDX_W'(0);
  localparam logic [PENALTY_W-1:0] PENALTY_RESET = PENALTY_W'(30);

  // Extra cycles charged when a dirty line is written back.
  localparam logic [ACC_CYC_W-1:0] WRITEBACK_CYCLES = ACC_CYC_W'(2);

  // Request kinds.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_STORE = 1'b1;

  // Default geometry.
  localparam int WAYS_DEFAULT        = 2;
  localparam int SET_BITS_DEFAULT    = 10;
  localparam int OFFSET_BITS_DEFAULT = 5;
  localparam int ADDR_BITS_DEFAULT   = 32;

endpackage

/* design/salwc_if.sv */
interface salwc_req_if;
  import salwc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [ADDRESS_W-1:0] address;
  logic [INSTR_W-1:0]   instr_count;

  modport source (output valid, output req_type, output address, output instr_count,
                  input ready);
  modport sink   (input valid, input req_type, input address, input instr_count,
                  output ready);
endinterface

interface salwc_rsp_if;
  import salwc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 way_used;
  logic                 evicted_dirty;
  logic [ACC_CYC_W-1:0] access_cycles;
  logic [SUM_W-1:0]     total_cycles;
  logic [SUM_W-1:0]     instr_total;
  logic [CNT_W-1:0]     access_total;
  logic [CNT_W-1:0]     load_hit_count;
  logic [CNT_W-1:0]     load_miss_count;
  logic [CNT_W-1:0]     store_hit_count;
  logic [CNT_W-1:0]     store_miss_count;
  logic [CNT_W-1:0]     dirty_eviction_count;

  modport source (output valid, output hit, output way_used, output evicted_dirty,
                  output access_cycles, output total_cycles, output instr_total,
                  output access_total, output load_hit_count, output load_miss_count,
                  output store_hit_count, output store_miss_count,
                  output dirty_eviction_count, input ready);
  modport sink   (input valid, input hit, input way_used, input evicted_dirty,
                  input access_cycles, input total_cycles, input instr_total,
                  input access_total, input load_hit_count, input load_miss_count,
                  input store_hit_count, input store_miss_count,
                  input dirty_eviction_count, output ready);
endinterface

/* design/set_assoc_lru_writeback_cache_core.sv */
// Tag store of a set-associative, write-back, write-allocate cache with exact
// LRU replacement and saturating statistics.
//
// Channels: the req channel carries one access per beat (load or store, byte
// address, instruction count). The rsp channel returns one beat per access
// with hit, way, dirty-eviction flag, the cycles charged and a snapshot of all
// running statistics. The miss penalty is set through the APB register at
// byte address 0; writes are expected only while the block is idle.
//
// Timing: an access is looked up by one compare unit that visits the ways of
// the set one per cycle. An access passes through the states LOOK, SCAN, UPD,
// SUMI, SUMC and DONE before its response is registered, and a new request is
// taken only back in IDLE. The way scan and the shared adder set this.
//
// Reset: rst is synchronous. After it, the block sweeps the set memory one
// set per cycle to clear all 2**SET_BITS sets (1024 by default), with
// req.ready low. The register returns to 30 and all counters to zero.
//
// Stalls: the response waits in an output register. The next request is still
// taken, and its finished result is held inside until that register is free.
module set_assoc_lru_writeback_cache_core #(
  parameter int WAYS        = salwc_pkg::WAYS_DEFAULT,
  parameter int SET_BITS    = salwc_pkg::SET_BITS_DEFAULT,
  parameter int OFFSET_BITS = salwc_pkg::OFFSET_BITS_DEFAULT,
  parameter int ADDR_BITS   = salwc_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  salwc_req_if.sink                           req,
  salwc_rsp_if.source                         rsp,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [salwc_pkg::PADDR_W-1:0]       paddr,
  input  logic [salwc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [salwc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import salwc_pkg::*;

  // Geometry derived from the parameters.
  localparam int EFF_BITS = (ADDR_BITS < ADDRESS_W) ? ADDR_BITS : ADDRESS_W;
  localparam int TAG_RAW  = EFF_BITS - OFFSET_BITS - SET_BITS;
  localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int SETS     = 1 << SET_BITS;
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W   = WAY_W;

  localparam logic [ADDRESS_W-1:0] ADDR_MASK  = ADDRESS_W'((64'd1 << EFF_BITS) - 64'd1);
  localparam logic [SET_W-1:0]     SET_MASK   = SET_W'(SETS - 1);
  localparam logic [SET_W-1:0]     LAST_SET   = SET_W'(SETS - 1);
  localparam logic [WAY_W-1:0]     LAST_WAY   = WAY_W'(WAYS - 1);
  localparam logic [SUM_W-1:0]     SUM_MAX    = '1;
  localparam logic [CNT_W-1:0]     CNT_MAX    = '1;

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;
  localparam logic [2:0] ST_SUMI  = 3'd5;
  localparam logic [2:0] ST_SUMC  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  // One row per set holds all ways of that set.
  row_t mem [SETS];

  logic [2:0]           state;
  logic [SET_W-1:0]     clr_addr;
  logic [PENALTY_W-1:0] penalty_cycles;

  // Latched request.
  logic                 store_q;
  logic [SET_W-1:0]     set_q;
  logic [TAG_W-1:0]     tag_q;
  logic [INSTR_W-1:0]   icount_q;

  // Set read data and scan results.
  row_t                 row_q;
  logic [WAY_W-1:0]     scan_w;
  logic                 hit_f;
  logic [WAY_W-1:0]     hit_way;
  logic                 inv_f;
  logic [WAY_W-1:0]     inv_way;
  logic [WAY_W-1:0]     best_way;
  logic [RANK_W-1:0]    best_rank;

  // Per-access results.
  logic                 res_hit;
  logic                 res_way;
  logic                 res_dirty_ev;
  logic [ACC_CYC_W-1:0] cyc_q;

  // Statistics.
  logic [SUM_W-1:0]     cycle_sum;
  logic [SUM_W-1:0]     instr_sum;
  logic [CNT_W-1:0]     access_counter;
  logic [CNT_W-1:0]     load_hit_counter;
  logic [CNT_W-1:0]     load_miss_counter;
  logic [CNT_W-1:0]     store_hit_counter;
  logic [CNT_W-1:0]     store_miss_counter;
  logic [CNT_W-1:0]     dirty_evict_counter;

  // Output register.
  logic                 rsp_valid;
  logic                 out_hit;
  logic                 out_way;
  logic                 out_dirty_ev;
  logic [ACC_CYC_W-1:0] out_cyc;
  logic [SUM_W-1:0]     out_total_cycles;
  logic [SUM_W-1:0]     out_total_instr;
  logic [CNT_W-1:0]     out_access;
  logic [CNT_W-1:0]     out_load_hit;
  logic [CNT_W-1:0]     out_load_miss;
  logic [CNT_W-1:0]     out_store_hit;
  logic [CNT_W-1:0]     out_store_miss;
  logic [CNT_W-1:0]     out_dirty_evict;

  logic                 req_fire;
  logic                 out_free;
  logic                 cfg_write;
  logic [ADDRESS_W-1:0] addr_m;
  logic [ADDRESS_W-1:0] set_full;
  logic [ADDRESS_W-1:0] tag_full;
  line_t                cur_line;
  logic [WAY_W-1:0]     victim;
  logic                 dirty_ev;
  row_t                 new_row;
  logic                 mem_we;
  logic [SET_W-1:0]     mem_waddr;
  row_t                 mem_wdata;
  logic [SUM_W-1:0]     add_a;
  logic [SUM_W-1:0]     add_b;
  logic [SUM_W:0]       add_sum;
  logic [SUM_W-1:0]     add_res;

  // Handshakes and configuration port.
  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[PADDR_W-1:2] == REG_PENALTY) ?
                     APB_DATA_W'(penalty_cycles) : '0;

  // Address split: bits above ADDR_BITS are dropped before tag and set are taken.
  assign addr_m   = req.address & ADDR_MASK;
  assign set_full = addr_m >> OFFSET_BITS;
  assign tag_full = addr_m >> (OFFSET_BITS + SET_BITS);

  // The way under the shared compare unit this cycle.
  assign cur_line = row_q[scan_w];

  // Replacement choice: the hit way, else the first empty way, else the oldest.
  assign victim   = hit_f ? hit_way : (inv_f ? inv_way : best_way);
  assign dirty_ev = !hit_f && !inv_f && row_q[victim].dirty;

  // LRU update for the chosen way. Lines more recent than it age by one; an
  // empty line counts as older than every valid line.
  always_comb begin
    new_row = row_q;
    for (int i = 0; i < WAYS; i++) begin
      if ((WAY_W'(i) != victim) && row_q[i].valid &&
          (!row_q[victim].valid || (row_q[i].rank < row_q[victim].rank))) begin
        new_row[i].rank = row_q[i].rank + RANK_W'(1);
      end
    end
    new_row[victim].rank = '0;
    if (hit_f) begin
      if (store_q == REQ_STORE) begin
        new_row[victim].dirty = 1'b1;
      end
    end else begin
      new_row[victim].valid = 1'b1;
      new_row[victim].dirty = (store_q == REQ_STORE);
      new_row[victim].tag   = tag_q;
    end
  end

  // Set memory write port: the clearing sweep or the row update.
  assign mem_we    = (state == ST_CLEAR) || (state == ST_UPD);
  assign mem_waddr = (state == ST_CLEAR) ? clr_addr : set_q;
  assign mem_wdata = (state == ST_CLEAR) ? row_t'('0) : new_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    row_q <= mem[set_q];
  end

  // Shared saturating adder for the two 48-bit running totals.
  always_comb begin
    if (state == ST_SUMI) begin
      add_a = instr_sum;
      add_b = SUM_W'(icount_q);
    end else begin
      add_a = cycle_sum;
      add_b = SUM_W'(cyc_q);
    end
    add_sum = {1'b0, add_a} + {1'b0, add_b};
    add_res = add_sum[SUM_W] ? SUM_MAX : add_sum[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_CLEAR;
      clr_addr            <= '0;
      penalty_cycles      <= PENALTY_RESET;
      cycle_sum           <= '0;
      instr_sum           <= '0;
      access_counter      <= '0;
      load_hit_counter    <= '0;
      load_miss_counter   <= '0;
      store_hit_counter   <= '0;
      store_miss_counter  <= '0;
      dirty_evict_counter <= '0;
      rsp_valid           <= 1'b0;
    end else begin
      if (cfg_write && (paddr[PADDR_W-1:2] == REG_PENALTY)) begin
        penalty_cycles <= pwdata[PENALTY_W-1:0];
      end

      // A finished result loads the output register when it is empty or as the old beat leaves.
      priority if ((state == ST_DONE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + SET_W'(1);
          if (clr_addr == LAST_SET) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            state    <= ST_LOOK;
            store_q  <= req.req_type;
            set_q    <= set_full[SET_W-1:0] & SET_MASK;
            tag_q    <= tag_full[TAG_W-1:0];
            icount_q <= req.instr_count;
            scan_w   <= '0;
            hit_f    <= 1'b0;
            inv_f    <= 1'b0;
          end
        end
        ST_LOOK: begin
          // The set row is read at the end of this cycle.
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (!hit_f && cur_line.valid && (cur_line.tag == tag_q)) begin
            hit_f   <= 1'b1;
            hit_way <= scan_w;
          end
          if (!inv_f && !cur_line.valid) begin
            inv_f   <= 1'b1;
            inv_way <= scan_w;
          end
          if ((scan_w == '0) || (cur_line.rank > best_rank)) begin
            best_way  <= scan_w;
            best_rank <= cur_line.rank;
          end
          scan_w <= scan_w + WAY_W'(1);
          if (scan_w == LAST_WAY) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          res_hit      <= hit_f;
          res_way      <= victim[0];
          res_dirty_ev <= dirty_ev;
          cyc_q        <= ACC_CYC_W'(icount_q)
                        + (hit_f ? ACC_CYC_W'(0) : ACC_CYC_W'(penalty_cycles))
                        + (dirty_ev ? WRITEBACK_CYCLES : ACC_CYC_W'(0));
          if (access_counter != CNT_MAX) begin
            access_counter <= access_counter + CNT_W'(1);
          end
          if (dirty_ev && (dirty_evict_counter != CNT_MAX)) begin
            dirty_evict_counter <= dirty_evict_counter + CNT_W'(1);
          end
          priority if (hit_f && (store_q == REQ_STORE)) begin
            if (store_hit_counter != CNT_MAX) begin
              store_hit_counter <= store_hit_counter + CNT_W'(1);
            end
          end else if (hit_f) begin
            if (load_hit_counter != CNT_MAX) begin
              load_hit_counter <= load_hit_counter + CNT_W'(1);
            end
          end else if (store_q == REQ_STORE) begin
            if (store_miss_counter != CNT_MAX) begin
              store_miss_counter <= store_miss_counter + CNT_W'(1);
            end
          end else begin
            if (load_miss_counter != CNT_MAX) begin
              load_miss_counter <= load_miss_counter + CNT_W'(1);
            end
          end
          state <= ST_SUMI;
        end
        ST_SUMI: begin
          instr_sum <= add_res;
          state     <= ST_SUMC;
        end
        ST_SUMC: begin
          cycle_sum <= add_res;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          // Hold the finished result until the output register can take it.
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output payload is captured together with the valid flag.
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_hit          <= res_hit;
      out_way          <= res_way;
      out_dirty_ev     <= res_dirty_ev;
      out_cyc          <= cyc_q;
      out_total_cycles <= cycle_sum;
      out_total_instr  <= instr_sum;
      out_access       <= access_counter;
      out_load_hit     <= load_hit_counter;
      out_load_miss    <= load_miss_counter;
      out_store_hit    <= store_hit_counter;
      out_store_miss   <= store_miss_counter;
      out_dirty_evict  <= dirty_evict_counter;
    end
  end

  assign rsp.valid                = rsp_valid;
  assign rsp.hit                  = out_hit;
  assign rsp.way_used             = out_way;
  assign rsp.evicted_dirty        = out_dirty_ev;
  assign rsp.access_cycles        = out_cyc;
  assign rsp.total_cycles         = out_total_cycles;
  assign rsp.instr_total          = out_total_instr;
  assign rsp.access_total         = out_access;
  assign rsp.load_hit_count       = out_load_hit;
  assign rsp.load_miss_count      = out_load_miss;
  assign rsp.store_hit_count      = out_store_hit;
  assign rsp.store_miss_count     = out_store_miss;
  assign rsp.dirty_eviction_count = out_dirty_evict;

endmodule

/* design/salwc_checker.sv */
module salwc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic                           hit,
  input logic                           evicted_dirty,
  input logic [salwc_pkg::ACC_CYC_W-1:0] access_cycles,
  input logic [salwc_pkg::SUM_W-1:0]    total_cycles,
  input logic [salwc_pkg::CNT_W-1:0]    access_total
);
  import salwc_pkg::*;

  // A stalled response beat keeps its valid, its access count and its access cycles.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(access_total) &&
                                $stable(access_cycles))
    else $error("response changed while stalled");

  // One access at a time: the request side closes right after a beat.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while an access is in progress");

  // A hit never reports a dirty eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && hit |-> !evicted_dirty)
    else $error("dirty eviction reported on a hit");

  // The running total includes the cycles of the access it is reported with.
  a_total_covers: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> total_cycles >= SUM_W'(access_cycles))
    else $error("total cycles below access cycles");

  // Every response counts at least its own access.
  a_access_counted: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> access_total != '0)
    else $error("response with zero access count");

endmodule

bind set_assoc_lru_writeback_cache_core salwc_checker u_salwc_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .hit           (rsp.hit),
  .evicted_dirty (rsp.evicted_dirty),
  .access_cycles (rsp.access_cycles),
  .total_cycles  (rsp.total_cycles),
  .access_total  (rsp.access_total)
);
